/* rtl/wsp_pkg.sv */
// Shared types and constants of the wave stream parser.
`timescale 1ns / 1ps
package wsp_pkg;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [31:0] TAG_DATA = 32'h61746164;
    localparam logic [31:0] TAG_RIFF = 32'h46464952;
    localparam logic [31:0] TAG_WAVE = 32'h45564157;
    localparam logic [31:0] TAG_JUNK = 32'h4b4e554a;
    localparam logic [31:0] TAG_FMT  = 32'h20746d66;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_INFO   = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;
    localparam logic [1:0] KIND_DONE   = 2'd3;

    localparam logic [3:0] ERR_NONE    = 4'd0;
    localparam logic [3:0] ERR_RIFF    = 4'd1;
    localparam logic [3:0] ERR_WAVE    = 4'd2;
    localparam logic [3:0] ERR_FMT_ID  = 4'd3;
    localparam logic [3:0] ERR_FMT_SZ  = 4'd4;
    localparam logic [3:0] ERR_FORMAT  = 4'd5;
    localparam logic [3:0] ERR_BRATE   = 4'd6;
    localparam logic [3:0] ERR_ALIGN   = 4'd7;
    localparam logic [3:0] ERR_BITS    = 4'd8;
    localparam logic [3:0] ERR_EXTRA   = 4'd9;
    localparam logic [3:0] ERR_COMBO   = 4'd10;
    localparam logic [3:0] ERR_TRUNC   = 4'd11;

    localparam logic [15:0] FMT_PCM   = 16'd1;
    localparam logic [15:0] FMT_FLOAT = 16'd3;

    // One queued request; then_done appends a done result after it.
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] value;
        logic        flt;
        logic [30:0] rate;
        logic [15:0] chans;
        logic [3:0]  err;
        logic        last;
        logic        then_done;
    } req_t;

    localparam int REQ_W = $bits(req_t);
endpackage

/* rtl/wsp_queue.sv */
// Short request queue between parser front and output back.
`timescale 1ns / 1ps
module wsp_queue #(
    parameter int DEPTH = wsp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  wsp_pkg::req_t push_req,
    input  logic          pop,
    output wsp_pkg::req_t head_req,
    output logic          not_empty,
    output logic          almost_full
);
    localparam int PW = $clog2(DEPTH);

    wsp_pkg::req_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]   count_reg;

    assign head_req    = mem_reg[rd_ptr_reg];
    assign not_empty   = (count_reg != '0);
    assign almost_full = (count_reg >= (PW+1)'(DEPTH - 1));

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_req;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop) count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end
endmodule

/* rtl/wsp_front.sv */
// Header parser and sample assembler: bytes in, result requests out.
`timescale 1ns / 1ps
module wsp_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_take,
    input  logic [7:0]    in_byte,
    input  logic          in_end,
    output logic          busy,
    output logic          push_reg,
    output wsp_pkg::req_t req_reg
);
    typedef enum logic [4:0] {
        P_RIFF_TAG, P_RIFF_SIZE, P_WAVE_TAG, P_C1_ID, P_C1_SIZE, P_JUNK_SKIP,
        P_C1_ID2, P_C1_SIZE2, P_AFMT, P_CHAN, P_RATE, P_BRATE, P_ALIGN, P_BITS,
        P_MUL1, P_MUL2, P_CMP, P_EXTRA, P_C2_ID, P_C2_SIZE, P_C2_SKIP, P_DATA,
        P_END
    } phase_t;

    phase_t        phase_reg, phase_next;
    logic [1:0]    idx_reg, idx_next;
    logic [31:0]   asm_reg, asm_next;
    logic [31:0]   left_reg, left_next;
    logic          fmt18_reg, fmt18_next;
    logic [15:0]   fcode_reg, fcode_next;
    logic [15:0]   chans_reg, chans_next;
    logic [31:0]   rate_reg, rate_next;
    logic [31:0]   brate_reg, brate_next;
    logic [15:0]   align_reg, align_next;
    logic [15:0]   bits16_reg, bits16_next;
    logic [5:0]    bits_reg, bits_next;
    logic [31:0]   prod1_reg, prod1_next;
    logic [63:0]   prod2_reg, prod2_next;
    logic [31:0]   pos_reg, pos_next;
    logic [31:0]   held_reg, held_next;
    logic          push_next;
    wsp_pkg::req_t req_next;

    logic          len4, done;
    logic [31:0]   word;
    logic [31:0]   held_new, smp, pos_inc;
    logic [2:0]    bps;
    logic          is_flt;

    assign busy = (phase_reg == P_MUL1) || (phase_reg == P_MUL2) || (phase_reg == P_CMP);

    always_comb begin
        len4 = !((phase_reg == P_AFMT) || (phase_reg == P_CHAN) ||
                 (phase_reg == P_ALIGN) || (phase_reg == P_BITS) ||
                 (phase_reg == P_EXTRA));
        done = len4 ? (idx_reg == 2'd3) : (idx_reg == 2'd1);
        word = asm_reg | ({24'd0, in_byte} << {idx_reg, 3'b000});
        is_flt = (fcode_reg == wsp_pkg::FMT_FLOAT);
        bps = bits_reg[5:3];
        pos_inc = pos_reg + 32'd1;
        held_new = held_reg;
        if (pos_reg < {29'd0, bps}) begin
            held_new = held_reg | ({24'd0, in_byte} << {pos_reg[1:0], 3'b000});
        end
        if (is_flt) smp = held_new;
        else if (bits_reg == 6'd8) smp = {~held_new[7], held_new[6:0], 24'd0};
        else if (bits_reg == 6'd16) smp = {held_new[15:0], 16'd0};
        else smp = held_new;

        phase_next = phase_reg;
        idx_next   = idx_reg;
        asm_next   = asm_reg;
        left_next  = left_reg;
        fmt18_next = fmt18_reg;
        fcode_next = fcode_reg;
        chans_next = chans_reg;
        rate_next  = rate_reg;
        brate_next = brate_reg;
        align_next = align_reg;
        bits16_next = bits16_reg;
        bits_next  = bits_reg;
        prod1_next = chans_reg * bits16_reg;
        prod2_next = rate_reg * prod1_reg;
        pos_next   = pos_reg;
        held_next  = held_reg;
        push_next  = 1'b0;
        req_next   = '0;

        if (phase_reg == P_CMP) begin
            push_next = 1'b1;
            req_next.kind = wsp_pkg::KIND_ERROR;
            req_next.last = 1'b1;
            phase_next = P_END;
            if (prod2_reg[63:3] != {29'd0, brate_reg}) req_next.err = wsp_pkg::ERR_BRATE;
            else if (prod1_reg[31:3] != {13'd0, align_reg})
                req_next.err = wsp_pkg::ERR_ALIGN;
            else if (bits16_reg != 16'd8 && bits16_reg != 16'd16 && bits16_reg != 16'd32)
                req_next.err = wsp_pkg::ERR_BITS;
            else begin
                push_next = 1'b0;
                req_next  = '0;
                bits_next = bits16_reg[5:0];
                phase_next = fmt18_reg ? P_EXTRA : P_C2_ID;
            end
        end else if (phase_reg == P_MUL1) begin
            phase_next = P_MUL2;
        end else if (phase_reg == P_MUL2) begin
            phase_next = P_CMP;
        end else if (in_take && phase_reg != P_END) begin
            if (in_end) begin
                push_next = 1'b1;
                req_next.kind = wsp_pkg::KIND_ERROR;
                req_next.err  = wsp_pkg::ERR_TRUNC;
                req_next.last = 1'b1;
                phase_next = P_END;
            end else begin
                if (phase_reg != P_JUNK_SKIP && phase_reg != P_C2_SKIP &&
                    phase_reg != P_DATA) begin
                    idx_next = done ? 2'd0 : idx_reg + 2'd1;
                    asm_next = done ? 32'd0 : word;
                end
                // Error request template; push_next decides whether it goes.
                req_next.kind = wsp_pkg::KIND_ERROR;
                req_next.last = 1'b1;
                unique case (phase_reg)
                    P_RIFF_TAG: if (done) begin
                        if (word != wsp_pkg::TAG_RIFF) begin
                            push_next = 1'b1; req_next.err = wsp_pkg::ERR_RIFF;
                            phase_next = P_END;
                        end else phase_next = P_RIFF_SIZE;
                    end
                    P_RIFF_SIZE: if (done) phase_next = P_WAVE_TAG;
                    P_WAVE_TAG: if (done) begin
                        if (word != wsp_pkg::TAG_WAVE) begin
                            push_next = 1'b1; req_next.err = wsp_pkg::ERR_WAVE;
                            phase_next = P_END;
                        end else phase_next = P_C1_ID;
                    end
                    P_C1_ID: if (done) begin left_next = word; phase_next = P_C1_SIZE; end
                    P_C1_ID2: if (done) begin left_next = word; phase_next = P_C1_SIZE2; end
                    P_C2_ID: if (done) begin left_next = word; phase_next = P_C2_SIZE; end
                    P_C1_SIZE, P_C1_SIZE2: if (done) begin
                        if (phase_reg == P_C1_SIZE && left_reg == wsp_pkg::TAG_JUNK) begin
                            left_next = word;
                            phase_next = (word == 32'd0) ? P_C1_ID2 : P_JUNK_SKIP;
                        end else if (left_reg != wsp_pkg::TAG_FMT) begin
                            push_next = 1'b1; req_next.err = wsp_pkg::ERR_FMT_ID;
                            phase_next = P_END;
                        end else if (word != 32'd16 && word != 32'd18) begin
                            push_next = 1'b1; req_next.err = wsp_pkg::ERR_FMT_SZ;
                            phase_next = P_END;
                        end else begin
                            fmt18_next = (word == 32'd18);
                            phase_next = P_AFMT;
                        end
                    end
                    P_JUNK_SKIP, P_C2_SKIP: begin
                        left_next = left_reg - 32'd1;
                        if (left_reg == 32'd1)
                            phase_next = (phase_reg == P_JUNK_SKIP) ? P_C1_ID2 : P_C2_ID;
                    end
                    P_AFMT: if (done) begin
                        fcode_next = word[15:0];
                        if (word[15:0] != wsp_pkg::FMT_PCM && word[15:0] != wsp_pkg::FMT_FLOAT)
                        begin
                            push_next = 1'b1; req_next.err = wsp_pkg::ERR_FORMAT;
                            phase_next = P_END;
                        end else phase_next = P_CHAN;
                    end
                    P_CHAN: if (done) begin chans_next = word[15:0]; phase_next = P_RATE; end
                    P_RATE: if (done) begin rate_next = word; phase_next = P_BRATE; end
                    P_BRATE: if (done) begin brate_next = word; phase_next = P_ALIGN; end
                    P_ALIGN: if (done) begin align_next = word[15:0]; phase_next = P_BITS; end
                    P_BITS: if (done) begin bits16_next = word[15:0]; phase_next = P_MUL1; end
                    P_EXTRA: if (done) begin
                        if (word[15:0] != 16'd0) begin
                            push_next = 1'b1; req_next.err = wsp_pkg::ERR_EXTRA;
                            phase_next = P_END;
                        end else phase_next = P_C2_ID;
                    end
                    P_C2_SIZE: if (done) begin
                        if (left_reg != wsp_pkg::TAG_DATA) begin
                            left_next = word;
                            phase_next = (word == 32'd0) ? P_C2_ID : P_C2_SKIP;
                        end else if (chans_reg == 16'd0 || (is_flt && bits_reg != 6'd32)) begin
                            push_next = 1'b1; req_next.err = wsp_pkg::ERR_COMBO;
                            phase_next = P_END;
                        end else begin
                            push_next = 1'b1;
                            req_next = '0;
                            req_next.kind  = wsp_pkg::KIND_INFO;
                            req_next.flt   = is_flt;
                            req_next.rate  = rate_reg[30:0];
                            req_next.chans = chans_reg;
                            req_next.then_done = (word == 32'd0);
                            left_next = word;
                            pos_next  = 32'd0;
                            held_next = 32'd0;
                            phase_next = (word == 32'd0) ? P_END : P_DATA;
                        end
                    end
                    P_DATA: begin
                        req_next = '0;
                        held_next = held_new;
                        pos_next  = pos_inc;
                        left_next = left_reg - 32'd1;
                        if (pos_inc == {16'd0, align_reg}) begin
                            push_next = 1'b1;
                            req_next.kind  = wsp_pkg::KIND_SAMPLE;
                            req_next.value = smp;
                            req_next.flt   = is_flt;
                            pos_next  = 32'd0;
                            held_next = 32'd0;
                        end
                        if (left_reg == 32'd1) begin
                            phase_next = P_END;
                            if (push_next) req_next.then_done = 1'b1;
                            else begin
                                push_next = 1'b1;
                                req_next.kind = wsp_pkg::KIND_DONE;
                                req_next.last = 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= P_RIFF_TAG;
            idx_reg   <= '0;
            asm_reg   <= '0;
            left_reg  <= '0;
            fmt18_reg <= 1'b0;
            fcode_reg <= '0;
            chans_reg <= '0;
            rate_reg  <= '0;
            brate_reg <= '0;
            align_reg <= '0;
            bits_reg  <= '0;
            pos_reg   <= '0;
            held_reg  <= '0;
            push_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            asm_reg   <= asm_next;
            left_reg  <= left_next;
            fmt18_reg <= fmt18_next;
            fcode_reg <= fcode_next;
            chans_reg <= chans_next;
            rate_reg  <= rate_next;
            brate_reg <= brate_next;
            align_reg <= align_next;
            bits_reg  <= bits_next;
            pos_reg   <= pos_next;
            held_reg  <= held_next;
            push_reg  <= push_next;
        end
        bits16_reg <= bits16_next;
        prod1_reg  <= prod1_next;
        prod2_reg  <= prod2_next;
        req_reg    <= req_next;
    end
endmodule

/* rtl/wsp_back.sv */
// Output stage: drains the queue and expands a request into one or two results.
`timescale 1ns / 1ps
module wsp_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  wsp_pkg::req_t head_req,
    input  logic          not_empty,
    output logic          pop,
    input  logic          m_ready,
    output logic          m_valid_reg,
    output wsp_pkg::req_t out_reg
);
    logic          pend_done_reg;
    logic          load;
    wsp_pkg::req_t done_req;

    always_comb begin
        done_req = '0;
        done_req.kind = wsp_pkg::KIND_DONE;
        done_req.last = 1'b1;
        load = !m_valid_reg || m_ready;
        pop  = load && !pend_done_reg && not_empty;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg   <= 1'b0;
            pend_done_reg <= 1'b0;
        end else if (load) begin
            if (pend_done_reg) begin
                m_valid_reg   <= 1'b1;
                pend_done_reg <= 1'b0;
            end else begin
                m_valid_reg   <= not_empty;
                pend_done_reg <= not_empty && head_req.then_done;
            end
        end
        if (load) begin
            out_reg <= pend_done_reg ? done_req : head_req;
        end
    end
endmodule

/* rtl/wave_stream_parser_top.sv */
// Top level of the byte-serial RIFF/WAVE parser.
`timescale 1ns / 1ps
// Throughput: one byte per cycle, except while the byte-rate product goes through
// the multiplier and compare states after the bits-per-sample field,
// and any cycle in which the request queue is nearly full.
// A request is registered in the front end, queued, then loaded into the output
// register (m_tvalid); byte-rate, align and bits errors wait for the multiplier.
// Reset (aresetn low, synchronous) returns the parser to the RIFF tag and
// empties the request queue and the output register.
module wave_stream_parser_top #(
    parameter int QUEUE_DEPTH = wsp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // [31:0] sample_value, [62:32] rate_hz,
                                   // [78:63] channel_count, [82:79] error_code
    output logic [2:0]  m_tuser,   // [1:0] result_kind, [2] sample_is_float
    output logic        m_tlast    // last
);
    logic          busy, push, almost_full, not_empty, pop, take;
    wsp_pkg::req_t push_req, head_req, out_req;

    // Hold input while the header check runs or the queue could overflow.
    assign s_tready = !busy && !almost_full;
    assign take     = s_tvalid && s_tready;

    wsp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_take  (take),
        .in_byte  (s_tdata),
        .in_end   (s_tlast),
        .busy     (busy),
        .push_reg (push),
        .req_reg  (push_req)
    );

    wsp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (push),
        .push_req    (push_req),
        .pop         (pop),
        .head_req    (head_req),
        .not_empty   (not_empty),
        .almost_full (almost_full)
    );

    wsp_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_req    (head_req),
        .not_empty   (not_empty),
        .pop         (pop),
        .m_ready     (m_tready),
        .m_valid_reg (m_tvalid),
        .out_reg     (out_req)
    );

    // Pack the result request onto the stream bus.
    assign m_tdata = {5'd0, out_req.err, out_req.chans, out_req.rate, out_req.value};
    assign m_tuser = {out_req.flt, out_req.kind};
    assign m_tlast = out_req.last;
endmodule
